>>> design/obt_pkg.sv
// obt_pkg: shared types, widths and helper functions for the oriented-box
// overlap test. Used by every module of the block; depends on nothing.
package obt_pkg;

  localparam int CW    = 24;            // centre, signed Q15.8
  localparam int QW    = 16;            // quaternion / axis, signed Q1.14
  localparam int HW    = 23;            // half extent, unsigned Q15.8
  localparam int DW    = CW + 1;        // centre difference
  localparam int LW    = 19;            // test axis component (cross axes grow)
  localparam int MA_W  = 25;            // multiplier operand A
  localparam int MB_W  = 35;            // multiplier operand B
  localparam int PW    = MA_W + MB_W;   // full product
  localparam int PQW   = 32;            // quaternion component product
  localparam int ACC_W = 48;            // dot product accumulator
  localparam int MAG_W = 35;            // |axis . box axis|
  localparam int RAD_W = 62;            // projected radius sum
  localparam int CMP_W = 64;            // separation compare
  localparam int RSH   = 14;            // Q14 rounding shift
  localparam int EW    = 36;            // rotation matrix entry before rounding

  localparam logic [4:0] LAST_SLOT  = 5'd26;
  localparam logic [4:0] LAST_QPROD = 5'd8;
  localparam logic [4:0] LAST_CROSS = 5'd5;
  localparam logic [2:0] LAST_FACE  = 3'd5;
  localparam logic [1:0] LAST_IDX   = 2'd2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [2:0][CW-1:0]   ctr;
    logic [3:0][QW-1:0]   rot;   // 0 w, 1 x, 2 y, 3 z
    logic [2:0][HW-1:0]   half;
  } item_t;

  // front to back: head of the input queue
  typedef struct packed {
    logic  vld;
    logic  is_test;
    item_t item;
  } fr_t;

  // back to result queue
  typedef struct packed {
    logic push;
    logic overlap;
  } res_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_QP,
    WB_DIST,
    WB_MAG,
    WB_RAD,
    WB_CROSS
  } wb_e;

  typedef struct packed {
    wb_e        wb;
    logic       last;
    logic       neg;
    logic [3:0] idx;
  } tag_t;

  typedef enum logic [1:0] {
    SK_DIST,
    SK_PROJ,
    SK_RAD
  } sk_e;

  typedef struct packed {
    sk_e        kind;
    logic [2:0] grp;
    logic [1:0] k;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUAT,
    ST_QDRAIN,
    ST_AXES,
    ST_SETAX,
    ST_CROSS,
    ST_CDRAIN,
    ST_TEST,
    ST_TDRAIN,
    ST_CMP,
    ST_OUT
  } st_e;

  // Axis test schedule: centre dot, then six box-axis dots, each radius
  // product issued once the following group's dots are under way.
  function automatic slot_t slot_decode(input logic [4:0] s);
    slot_t      r;
    logic [4:0] t;
    r = '{kind: SK_DIST, grp: 3'd0, k: 2'd0};
    t = s - 5'd9;
    priority if (s < 5'd3) begin
      r.kind = SK_DIST;
      r.k    = s[1:0];
    end else if (s < 5'd6) begin
      r.kind = SK_PROJ;
      r.grp  = 3'd0;
      r.k    = 2'(s - 5'd3);
    end else if (s < 5'd9) begin
      r.kind = SK_PROJ;
      r.grp  = 3'd1;
      r.k    = 2'(s - 5'd6);
    end else if (t == 5'd17) begin
      r.kind = SK_RAD;
      r.grp  = 3'd5;
    end else if (t[1:0] == 2'd0) begin
      r.kind = SK_RAD;
      r.grp  = t[4:2];
    end else begin
      r.kind = SK_PROJ;
      r.grp  = t[4:2] + 3'd2;
      r.k    = t[1:0] - 2'd1;
    end
    return r;
  endfunction

  // cross component terms: {a index, b index}
  function automatic logic [3:0] cross_ops(input logic [2:0] c);
    logic [3:0] r;
    unique case (c)
      3'd0:    r = {2'd1, 2'd2};
      3'd1:    r = {2'd2, 2'd1};
      3'd2:    r = {2'd2, 2'd0};
      3'd3:    r = {2'd0, 2'd2};
      3'd4:    r = {2'd0, 2'd1};
      3'd5:    r = {2'd1, 2'd0};
      default: r = {2'd0, 2'd0};
    endcase
    return r;
  endfunction

  // quaternion products xx yy zz xy xz yz wx wy wz
  function automatic logic [3:0] quat_ops(input logic [3:0] c);
    logic [3:0] r;
    unique case (c)
      4'd0:    r = {2'd1, 2'd1};
      4'd1:    r = {2'd2, 2'd2};
      4'd2:    r = {2'd3, 2'd3};
      4'd3:    r = {2'd1, 2'd2};
      4'd4:    r = {2'd1, 2'd3};
      4'd5:    r = {2'd2, 2'd3};
      4'd6:    r = {2'd0, 2'd1};
      4'd7:    r = {2'd0, 2'd2};
      4'd8:    r = {2'd0, 2'd3};
      default: r = {2'd0, 2'd0};
    endcase
    return r;
  endfunction

endpackage

>>> design/obt_front.sv
// obt_front: two-word input queue that takes box words and tags them as
// load or test for the back end. Depends on obt_pkg.
module obt_front import obt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push,
  output logic  full,
  input  item_t item_i,
  output fr_t   head_o,
  input  logic  take_i
);

  logic [1:0] cnt_q, cnt_d;
  item_t      ent_q [2];
  logic       wr, rd;

  assign wr = push && !full;
  assign rd = take_i && (cnt_q != 2'd0);
  assign full = (cnt_q == 2'd2);

  always_comb begin
    cnt_d = cnt_q + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // new word lands in the first free slot after any shift
  always_ff @(posedge clk_i) begin
    if (wr && ((cnt_q - 2'(rd)) == 2'd0)) begin
      ent_q[0] <= item_i;
    end else if (rd) begin
      ent_q[0] <= ent_q[1];
    end
    if (wr && ((cnt_q - 2'(rd)) != 2'd0)) begin
      ent_q[1] <= item_i;
    end
  end

  assign head_o.vld     = (cnt_q != 2'd0);
  assign head_o.is_test = (ent_q[0].cmd == CMD_TEST);
  assign head_o.item    = ent_q[0];

endmodule

>>> design/obt_resq.sv
// obt_resq: two-word result queue between the back end and the result port.
// Depends on obt_pkg.
module obt_resq import obt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  res_t res_i,
  output logic rfull_o,
  output logic empty,
  input  logic pop,
  output logic overlap_o
);

  logic [1:0] cnt_q;
  logic       ent_q [2];
  logic       wr, rd;

  assign wr      = res_i.push && !rfull_o;
  assign rd      = pop && !empty;
  assign rfull_o = (cnt_q == 2'd2);
  assign empty   = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr && ((cnt_q - 2'(rd)) == 2'd0)) begin
      ent_q[0] <= res_i.overlap;
    end else if (rd) begin
      ent_q[0] <= ent_q[1];
    end
    if (wr && ((cnt_q - 2'(rd)) != 2'd0)) begin
      ent_q[1] <= res_i.overlap;
    end
  end

  assign overlap_o = ent_q[0];

endmodule

>>> design/obt_back.sv
// obt_back: sequencer and shared multiply-accumulate unit that turns the
// quaternion into axes and runs the fifteen axis tests. Depends on obt_pkg.
module obt_back import obt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  fr_t  head_i,
  output logic take_o,
  output res_t res_o,
  input  logic rfull_i
);

  st_e  state_q, state_d;
  logic [4:0] cnt_q;
  logic [2:0] ax_q;
  logic [1:0] ci_q, cj_q;
  logic       cross_q;
  logic       ovl_q;
  logic       sep;

  item_t                  item_q;
  logic signed [DW-1:0]   d_q   [3];
  logic signed [PQW-1:0]  p_q   [9];
  logic signed [QW-1:0]   cax_q [3][3];
  logic signed [QW-1:0]   rax_q [3][3];
  logic signed [CW-1:0]   rc_q  [3];
  logic [HW-1:0]          rh_q  [3];
  logic signed [LW-1:0]   l_q   [3];
  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]       dist_q;
  logic [MAG_W-1:0]       mag_q;
  logic [RAD_W-1:0]       rad_q;
  logic signed [PW-1:0]   prod_q, prod_d;
  tag_t                   tag_q, tag_d;

  logic signed [MA_W-1:0] opa;
  logic signed [MB_W-1:0] opb;
  slot_t                  sl;
  logic [3:0]             qo, co;
  logic [1:0]             g2;

  logic signed [EW-1:0]   pe  [9];
  logic signed [EW-1:0]   m   [9];
  logic signed [EW-1:0]   mr  [9];
  logic signed [QW-1:0]   axc [9];

  logic signed [ACC_W-1:0] prod_t, acc_sum, abs_sum, rnd;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (head_i.vld) state_d = ST_QUAT;
      ST_QUAT:   if (cnt_q == LAST_QPROD) state_d = ST_QDRAIN;
      ST_QDRAIN: state_d = ST_AXES;
      ST_AXES:   state_d = (item_q.cmd == CMD_LOAD) ? ST_IDLE : ST_SETAX;
      ST_SETAX:  state_d = ST_TEST;
      ST_CROSS:  if (cnt_q == LAST_CROSS) state_d = ST_CDRAIN;
      ST_CDRAIN: state_d = ST_TEST;
      ST_TEST:   if (cnt_q == LAST_SLOT) state_d = ST_TDRAIN;
      ST_TDRAIN: state_d = ST_CMP;
      ST_CMP: begin
        priority if (sep) state_d = ST_OUT;
        else if (!cross_q) state_d = (ax_q == LAST_FACE) ? ST_CROSS : ST_SETAX;
        else if (ci_q == LAST_IDX && cj_q == LAST_IDX) state_d = ST_OUT;
        else state_d = ST_CROSS;
      end
      ST_OUT:    if (!rfull_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs / multiplier operands ----------------
  always_comb begin
    take_o      = (state_q == ST_IDLE);
    res_o.push  = (state_q == ST_OUT);
    res_o.overlap = ovl_q;
    opa   = '0;
    opb   = '0;
    tag_d = '{wb: WB_NONE, last: 1'b0, neg: 1'b0, idx: 4'd0};
    sl    = slot_decode(cnt_q);
    qo    = quat_ops(cnt_q[3:0]);
    co    = cross_ops(cnt_q[2:0]);
    g2    = 2'(sl.grp - 3'd3);
    unique case (state_q)
      ST_QUAT: begin
        opa = MA_W'($signed(item_q.rot[qo[3:2]]));
        opb = MB_W'($signed(item_q.rot[qo[1:0]]));
        tag_d = '{wb: WB_QP, last: 1'b0, neg: 1'b0, idx: cnt_q[3:0]};
      end
      ST_CROSS: begin
        opa = MA_W'(rax_q[ci_q][co[3:2]]);
        opb = MB_W'(cax_q[cj_q][co[1:0]]);
        tag_d = '{wb: WB_CROSS, last: cnt_q[0], neg: cnt_q[0],
                  idx: {2'd0, 2'(cnt_q[2:1])}};
      end
      ST_TEST: begin
        unique case (sl.kind)
          SK_DIST: begin
            opa = MA_W'(d_q[sl.k]);
            opb = MB_W'(l_q[sl.k]);
            tag_d = '{wb: WB_DIST, last: (sl.k == LAST_IDX), neg: 1'b0, idx: 4'd0};
          end
          SK_PROJ: begin
            opa = (sl.grp < 3'd3) ? MA_W'(rax_q[2'(sl.grp)][sl.k])
                                  : MA_W'(cax_q[g2][sl.k]);
            opb = MB_W'(l_q[sl.k]);
            tag_d = '{wb: WB_MAG, last: (sl.k == LAST_IDX), neg: 1'b0, idx: 4'd0};
          end
          SK_RAD: begin
            opa = (sl.grp < 3'd3) ? MA_W'(rh_q[2'(sl.grp)])
                                  : MA_W'(item_q.half[g2]);
            opb = MB_W'(mag_q);
            tag_d = '{wb: WB_RAD, last: 1'b0, neg: 1'b0, idx: 4'd0};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod_d = PW'(opa) * PW'(opb);

  // ---------------- accumulate stage ----------------
  always_comb begin
    prod_t  = ACC_W'(prod_q);
    acc_sum = acc_q + (tag_q.neg ? -prod_t : prod_t);
    abs_sum = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;
    rnd     = (acc_sum + ACC_W'(8192)) >>> RSH;
    sep     = ((CMP_W'(dist_q)) << RSH) > CMP_W'(rad_q);
  end

  // quaternion products to rotation matrix rows
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pe[i] = EW'(p_q[i]);
    end
    m[0] = (EW'(1) <<< 28) - ((pe[1] + pe[2]) <<< 1);
    m[1] = (pe[3] + pe[8]) <<< 1;
    m[2] = (pe[4] - pe[7]) <<< 1;
    m[3] = (pe[3] - pe[8]) <<< 1;
    m[4] = (EW'(1) <<< 28) - ((pe[0] + pe[2]) <<< 1);
    m[5] = (pe[5] + pe[6]) <<< 1;
    m[6] = (pe[4] + pe[7]) <<< 1;
    m[7] = (pe[5] - pe[6]) <<< 1;
    m[8] = (EW'(1) <<< 28) - ((pe[0] + pe[1]) <<< 1);
    for (int i = 0; i < 9; i++) begin
      mr[i] = (m[i] + EW'(8192)) >>> RSH;
      if (mr[i] > EW'(32767)) begin
        axc[i] = 16'sd32767;
      end else if (mr[i] < -EW'(32768)) begin
        axc[i] = -16'sd32768;
      end else begin
        axc[i] = QW'(mr[i]);
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 5'd0;
      tag_q   <= '{wb: WB_NONE, last: 1'b0, neg: 1'b0, idx: 4'd0};
      ax_q    <= 3'd0;
      ci_q    <= 2'd0;
      cj_q    <= 2'd0;
      cross_q <= 1'b0;
      ovl_q   <= 1'b0;
      acc_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        rc_q[i] <= '0;
        rh_q[i] <= '0;
        for (int k = 0; k < 3; k++) begin
          rax_q[i][k] <= (i == k) ? 16'sd16384 : 16'sd0;
        end
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
      tag_q   <= tag_d;
      if (state_q == ST_IDLE) begin
        ax_q    <= 3'd0;
        ci_q    <= 2'd0;
        cj_q    <= 2'd0;
        cross_q <= 1'b0;
      end
      if (state_q == ST_CMP) begin
        ovl_q <= !sep;
        if (!sep && !cross_q) begin
          if (ax_q == LAST_FACE) begin
            cross_q <= 1'b1;
          end else begin
            ax_q <= ax_q + 3'd1;
          end
        end else if (!sep) begin
          if (cj_q == LAST_IDX) begin
            cj_q <= 2'd0;
            ci_q <= ci_q + 2'd1;
          end else begin
            cj_q <= cj_q + 2'd1;
          end
        end
      end
      if (tag_q.wb == WB_DIST || tag_q.wb == WB_MAG || tag_q.wb == WB_CROSS) begin
        acc_q <= tag_q.last ? '0 : acc_sum;
      end
      if (state_q == ST_AXES && item_q.cmd == CMD_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          rc_q[i] <= $signed(item_q.ctr[i]);
          rh_q[i] <= item_q.half[i];
          for (int k = 0; k < 3; k++) begin
            rax_q[i][k] <= axc[3*i+k];
          end
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == ST_IDLE && head_i.vld) begin
      item_q <= head_i.item;
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= DW'(rc_q[k]) - DW'($signed(head_i.item.ctr[k]));
      end
    end
    if (state_q == ST_AXES) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          cax_q[i][k] <= axc[3*i+k];
        end
      end
    end
    if (state_q == ST_SETAX) begin
      for (int k = 0; k < 3; k++) begin
        l_q[k] <= ax_q[0] ? LW'(cax_q[2'(ax_q[2:1])][k])
                          : LW'(rax_q[2'(ax_q[2:1])][k]);
      end
    end
    if (state_q == ST_SETAX || state_q == ST_CDRAIN) begin
      rad_q <= '0;
    end else if (tag_q.wb == WB_RAD) begin
      rad_q <= rad_q + RAD_W'(prod_q);
    end
    unique case (tag_q.wb)
      WB_QP:    p_q[tag_q.idx] <= PQW'(prod_q);
      WB_DIST:  if (tag_q.last) dist_q <= abs_sum;
      WB_MAG:   if (tag_q.last) mag_q <= MAG_W'(abs_sum);
      WB_CROSS: if (tag_q.last) l_q[2'(tag_q.idx)] <= LW'(rnd);
      default: ;
    endcase
  end

`ifndef SYNTH
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST && cnt_q == 5'd0) |-> acc_q == '0)
    else $error("accumulator not clear at start of axis test");

  a_out_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> item_q.cmd == CMD_TEST)
    else $error("result produced for a load word");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> tag_q.wb == WB_NONE)
    else $error("multiplier write-back pending while idle");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AXES && item_q.cmd == CMD_LOAD) |=> state_q == ST_IDLE)
    else $error("load word did not retire after axis update");
`endif

endmodule

>>> design/obb_overlap_test_unit.sv
// obb_overlap_test_unit: separating-axis overlap test for two oriented boxes.
// Top level; instantiates obt_front, obt_back and obt_resq; uses obt_pkg.
//
//   channel   handshake         payload
//   --------  ----------------  ------------------------------------------
//   input     push / full       cmd, center_x/y/z, rot_w/x/y/z, half_x/y/z
//   result    empty / pop       overlap (one word per test word)
//
// A load word runs in the back end as 9 quaternion products on the shared
// multiplier, a drain step and the matrix update. A test word adds 27
// products per face axis for centre, projections and radius, and per cross
// axis 6 more that form the axis first; it ends early when an axis
// separates. The back end takes a new word only once done with the last,
// as all products share the single multiplier. Reset empties both queues
// and loads an identity reference box at the origin with zero extents. The
// input queue takes two words while the back end works and the result queue
// holds two words, so either side may stall without stopping the other.
module obb_overlap_test_unit import obt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic                 cmd_i,
  input  logic signed [CW-1:0] center_x_i,
  input  logic signed [CW-1:0] center_y_i,
  input  logic signed [CW-1:0] center_z_i,
  input  logic signed [QW-1:0] rot_w_i,
  input  logic signed [QW-1:0] rot_x_i,
  input  logic signed [QW-1:0] rot_y_i,
  input  logic signed [QW-1:0] rot_z_i,
  input  logic [HW-1:0]        half_x_i,
  input  logic [HW-1:0]        half_y_i,
  input  logic [HW-1:0]        half_z_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 overlap_o
);

  item_t in_word;
  fr_t   head;
  logic  take;
  res_t  res;
  logic  rfull;

  // pack the input word; rot order w, x, y, z
  always_comb begin
    in_word.cmd     = cmd_e'(cmd_i);
    in_word.ctr[0]  = center_x_i;
    in_word.ctr[1]  = center_y_i;
    in_word.ctr[2]  = center_z_i;
    in_word.rot[0]  = rot_w_i;
    in_word.rot[1]  = rot_x_i;
    in_word.rot[2]  = rot_y_i;
    in_word.rot[3]  = rot_z_i;
    in_word.half[0] = half_x_i;
    in_word.half[1] = half_y_i;
    in_word.half[2] = half_z_i;
  end

  // front: input queue, tags load vs test
  obt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (in_word),
    .head_o (head),
    .take_i (take)
  );

  // back: axis build and the fifteen axis tests on one MAC
  obt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .take_o  (take),
    .res_o   (res),
    .rfull_i (rfull)
  );

  // result queue
  obt_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .rfull_o   (rfull),
    .empty     (empty),
    .pop       (pop),
    .overlap_o (overlap_o)
  );

endmodule
